// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL files. Both sample on clk and are
// disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/gnhp_pkg.sv =====
package gnhp_pkg;

  // Header sections in parse order
  typedef enum logic [2:0] {
    SEC_BASIC,
    SEC_COMMON,
    SEC_BEACON,
    SEC_SHB,
    SEC_TSB,
    SEC_BTP,
    SEC_DONE
  } sec_t;

  // Packet status reported in the closing result
  typedef enum logic [2:0] {
    ST_OK,
    ST_TRUNC,
    ST_BADVER,
    ST_BADNH,
    ST_TYPE,
    ST_SUBTYPE
  } status_t;

  // Field codes
  localparam logic [4:0] FC_VERSION     = 5'd0;
  localparam logic [4:0] FC_BASIC_NH    = 5'd1;
  localparam logic [4:0] FC_BASIC_RSVD  = 5'd2;
  localparam logic [4:0] FC_LT_MULT     = 5'd3;
  localparam logic [4:0] FC_LT_BASE     = 5'd4;
  localparam logic [4:0] FC_LIFETIME    = 5'd5;
  localparam logic [4:0] FC_RHL         = 5'd6;
  localparam logic [4:0] FC_COMMON_NH   = 5'd7;
  localparam logic [4:0] FC_COMMON_RSVD = 5'd8;
  localparam logic [4:0] FC_HTYPE       = 5'd9;
  localparam logic [4:0] FC_HSUBTYPE    = 5'd10;
  localparam logic [4:0] FC_TCLASS      = 5'd11;
  localparam logic [4:0] FC_FLAGS       = 5'd12;
  localparam logic [4:0] FC_PLEN        = 5'd13;
  localparam logic [4:0] FC_MHL         = 5'd14;
  localparam logic [4:0] FC_RSVD2       = 5'd15;
  localparam logic [4:0] FC_GN_ADDR     = 5'd16;
  localparam logic [4:0] FC_TSTAMP      = 5'd17;
  localparam logic [4:0] FC_LAT         = 5'd18;
  localparam logic [4:0] FC_LON         = 5'd19;
  localparam logic [4:0] FC_PAI         = 5'd20;
  localparam logic [4:0] FC_SPEED       = 5'd21;
  localparam logic [4:0] FC_HEADING     = 5'd22;
  localparam logic [4:0] FC_SHB_DATA    = 5'd23;
  localparam logic [4:0] FC_TSB_SN      = 5'd24;
  localparam logic [4:0] FC_TSB_RSVD    = 5'd25;
  localparam logic [4:0] FC_BTP_DPORT   = 5'd26;
  localparam logic [4:0] FC_BTPA_SPORT  = 5'd27;
  localparam logic [4:0] FC_BTPB_DINFO  = 5'd28;
  localparam logic [4:0] FC_HDR_LEN     = 5'd29;
  localparam logic [4:0] FC_STATUS      = 5'd30;

  // Longest complete header: basic + common + extended + BTP
  localparam logic [5:0] HDR_MAX = 6'd44;

  // Lifetime base multipliers, in 50 ms units
  localparam logic [10:0] LT_SCALE [4] = '{11'd1, 11'd20, 11'd200, 11'd2000};

  typedef struct packed {
    logic        last;
    logic [63:0] value;
    logic [4:0]  code;
  } result_t;

  // Up to three results from one byte
  typedef struct packed {
    logic [1:0]       n;
    result_t [2:0]    r;
  } res_list_t;

  // Parser state carried from byte to byte
  typedef struct packed {
    sec_t        sec;
    logic [3:0]  htype;
    logic [3:0]  hsub;
    logic [3:0]  cnh;
    status_t     status;
    logic [5:0]  hbc;    // header bytes consumed
    logic [1:0]  bpos;   // packet byte position, saturates at 3
    logic [63:0] acc;    // field accumulator
  } state_t;

  localparam state_t STATE_RESET = '{
    sec: SEC_BASIC, htype: 4'd0, hsub: 4'd0, cnh: 4'd0, status: ST_OK,
    hbc: 6'd0, bpos: 2'd0, acc: 64'd0
  };

  function automatic logic [63:0] sext32(input logic [63:0] a);
    return {{32{a[31]}}, a[31:0]};
  endfunction

  function automatic logic [63:0] sext15(input logic [63:0] a);
    return {{49{a[14]}}, a[14:0]};
  endfunction

endpackage

// ===== rtl/core/geonetworking_header_parser_unit.sv =====
// GeoNetworking / BTP header parser.
// Input stream (s_*): one packet byte per transaction, first byte of the
// basic header first, s_tlast on the final byte of the packet.
// Output stream (m_*): one (field code, value) result per transaction.
// Each header field is reported when its last byte has arrived; the final
// byte of a packet adds a header-length result and a status result, and
// m_tlast marks the status result that closes the packet.
// A byte is registered in the input register, parsed from there into the
// result bank register, and its first result is driven on m_* from the bank.
// Throughput: one byte per cycle as long as each byte yields at most one
// result and m_tready stays high; a byte that yields two or three results
// holds the input while the three-entry result bank drains through the
// single output port.
// When m_tready is low, results hold in the bank and the input register
// keeps one byte, after which s_tready drops.
// Reset (rst, synchronous) empties both registers and returns the parser
// to the start of the basic header.
`include "assert_macros.svh"

module geonetworking_header_parser_unit import gnhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [4:0] field_code, [68:5] field_value, [71:69] zero
  output logic        m_tlast    // last_result
);

  logic        iv;
  logic [7:0]  ib;
  logic        il;
  state_t      st;
  state_t      st_next;
  res_list_t   step_res;
  result_t [2:0] slot;
  logic [1:0]  left;
  logic        take;
  logic        fire;

  gnhp_step u_step (
    .cur       (st),
    .data_byte (ib),
    .last_byte (il),
    .nxt       (st_next),
    .res       (step_res)
  );

  // Handshake: parse when the result bank is empty or emptying
  assign take     = m_tvalid && m_tready;
  assign fire     = iv && ((left == 2'd0) || (left == 2'd1 && take));
  assign s_tready = !iv || fire;

  assign m_tvalid = (left != 2'd0);
  assign m_tdata  = {3'b000, slot[0].value, slot[0].code};
  assign m_tlast  = slot[0].last;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      iv <= 1'b1;
    end else if (fire) begin
      iv <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      ib <= s_tdata;
      il <= s_tlast;
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (fire) begin
      st <= st_next;
    end
  end

  // Result bank: load on parse, shift down on each output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
    end else if (fire) begin
      left <= step_res.n;
    end else if (take) begin
      left <= left - 2'd1;
    end
    if (fire) begin
      slot <= step_res.r;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  `ASSERT_NEXT(a_clear_on_last, fire && il, st.sec == SEC_BASIC && st.hbc == 6'd0, "state not cleared after final byte")
  `ASSERT_ALWAYS(a_tlast_is_status, m_tvalid && m_tlast |-> slot[0].code == FC_STATUS, "tlast on non-status result")
  `ASSERT_ALWAYS(a_hbc_bound, st.hbc <= HDR_MAX, "header byte count beyond longest header")

endmodule

// ===== rtl/core/gnhp_step.sv =====
// Per-byte parse step: next state and the ordered result list for one byte.
module gnhp_step import gnhp_pkg::*; (
  input  state_t      cur,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output state_t      nxt,
  output res_list_t   res
);

  function automatic res_list_t mk1(input logic [4:0] c0, input logic [63:0] v0);
    res_list_t l;
    l = '0;
    l.n = 2'd1;
    l.r[0].code = c0;
    l.r[0].value = v0;
    return l;
  endfunction

  function automatic res_list_t mk2(input logic [4:0] c0, input logic [63:0] v0,
                                    input logic [4:0] c1, input logic [63:0] v1);
    res_list_t l;
    l = mk1(c0, v0);
    l.n = 2'd2;
    l.r[1].code = c1;
    l.r[1].value = v1;
    return l;
  endfunction

  // Long position vector fields by byte offset within the vector
  function automatic res_list_t lpv(input logic [4:0] lo, input logic [63:0] a);
    res_list_t l;
    l = '0;
    case (lo)
      5'd7:    l = mk1(FC_GN_ADDR, a);
      5'd11:   l = mk1(FC_TSTAMP, {32'd0, a[31:0]});
      5'd15:   l = mk1(FC_LAT, sext32(a));
      5'd19:   l = mk1(FC_LON, sext32(a));
      5'd21:   l = mk2(FC_PAI, {63'd0, a[15]}, FC_SPEED, sext15(a));
      5'd23:   l = mk1(FC_HEADING, {48'd0, a[15:0]});
      default: l = '0;
    endcase
    return l;
  endfunction

  // BTP follows only for next header 1 or 2
  function automatic sec_t after_ext(input logic [3:0] cnh);
    return (cnh == 4'd1 || cnh == 4'd2) ? SEC_BTP : SEC_DONE;
  endfunction

  logic [63:0] a;
  logic [5:0]  rel;
  logic [5:0]  trel;
  logic [5:0]  elen;
  logic [5:0]  brel;
  logic [2:0]  crel;
  logic [5:0]  lt_mult;
  logic [16:0] lt_prod;
  res_list_t   pend;
  logic        withhold;
  status_t     fin_status;
  result_t     hl_res;
  result_t     st_res;

  // Offsets and lifetime product
  always_comb begin
    a       = {cur.acc[55:0], data_byte};
    rel     = cur.hbc - 6'd12;
    trel    = rel - 6'd4;
    crel    = 3'(cur.hbc - 6'd4);
    if (cur.htype == 4'd1) begin
      elen = 6'd24;
    end else if (cur.htype == 4'd5 && cur.hsub <= 4'd1) begin
      elen = 6'd28;
    end else begin
      elen = 6'd0;
    end
    brel    = rel - elen;
    lt_mult = data_byte[7:2];
    lt_prod = 17'(lt_mult) * 17'(LT_SCALE[data_byte[1:0]]);
  end

  // Field extraction and section walk
  always_comb begin
    nxt  = cur;
    pend = '0;
    if (cur.sec != SEC_DONE) begin
      nxt.hbc = cur.hbc + 6'd1;
      nxt.acc = a;
      unique case (cur.sec)
        SEC_BASIC: begin
          unique case (cur.hbc[1:0])
            2'd0: begin
              if (data_byte[7:4] != 4'd1) begin
                pend = mk1(FC_VERSION, {60'd0, data_byte[7:4]});
                nxt.status = ST_BADVER;
                nxt.sec = SEC_DONE;
              end else begin
                pend = mk2(FC_VERSION, {60'd0, data_byte[7:4]},
                           FC_BASIC_NH, {60'd0, data_byte[3:0]});
                if (data_byte[3:0] != 4'd1) nxt.status = ST_BADNH;
              end
            end
            2'd1: pend = mk1(FC_BASIC_RSVD, {56'd0, data_byte});
            2'd2: begin
              pend = mk2(FC_LT_MULT, {58'd0, lt_mult},
                         FC_LT_BASE, {62'd0, data_byte[1:0]});
              pend.n = 2'd3;
              pend.r[2].code = FC_LIFETIME;
              pend.r[2].value = {47'd0, lt_prod};
            end
            default: begin
              pend = mk1(FC_RHL, {56'd0, data_byte});
              nxt.sec = (cur.status == ST_BADNH) ? SEC_DONE : SEC_COMMON;
            end
          endcase
        end
        SEC_COMMON: begin
          unique case (crel)
            3'd0: begin
              nxt.cnh = data_byte[7:4];
              pend = mk2(FC_COMMON_NH, {60'd0, data_byte[7:4]},
                         FC_COMMON_RSVD, {60'd0, data_byte[3:0]});
            end
            3'd1: begin
              nxt.htype = data_byte[7:4];
              nxt.hsub  = data_byte[3:0];
              pend = mk2(FC_HTYPE, {60'd0, data_byte[7:4]},
                         FC_HSUBTYPE, {60'd0, data_byte[3:0]});
            end
            3'd2: pend = mk1(FC_TCLASS, {56'd0, data_byte});
            3'd3: pend = mk1(FC_FLAGS, {56'd0, data_byte});
            3'd4: pend = '0;
            3'd5: pend = mk1(FC_PLEN, {48'd0, a[15:0]});
            3'd6: pend = mk1(FC_MHL, {56'd0, data_byte});
            default: begin
              pend = mk1(FC_RSVD2, {56'd0, data_byte});
              if (cur.htype == 4'd1) begin
                nxt.sec = SEC_BEACON;
              end else if (cur.htype == 4'd5) begin
                if (cur.hsub == 4'd0) begin
                  nxt.sec = SEC_SHB;
                end else if (cur.hsub == 4'd1) begin
                  nxt.sec = SEC_TSB;
                end else begin
                  nxt.status = ST_SUBTYPE;
                  nxt.sec = after_ext(cur.cnh);
                end
              end else begin
                nxt.status = ST_TYPE;
                nxt.sec = SEC_DONE;
              end
            end
          endcase
        end
        SEC_BEACON: begin
          pend = lpv(rel[4:0], a);
          if (rel >= 6'd23) nxt.sec = after_ext(cur.cnh);
        end
        SEC_SHB: begin
          if (rel < 6'd24) begin
            pend = lpv(rel[4:0], a);
          end else if (rel == 6'd27) begin
            pend = mk1(FC_SHB_DATA, {32'd0, a[31:0]});
          end
          if (rel >= 6'd27) nxt.sec = after_ext(cur.cnh);
        end
        SEC_TSB: begin
          if (rel == 6'd1) begin
            pend = mk1(FC_TSB_SN, {48'd0, a[15:0]});
          end else if (rel == 6'd3) begin
            pend = mk1(FC_TSB_RSVD, {48'd0, a[15:0]});
          end else if (rel >= 6'd4) begin
            pend = lpv(trel[4:0], a);
          end
          if (rel >= 6'd27) nxt.sec = after_ext(cur.cnh);
        end
        SEC_BTP: begin
          if (brel == 6'd1) begin
            pend = mk1(FC_BTP_DPORT, {48'd0, a[15:0]});
          end else if (brel >= 6'd3) begin
            pend = mk1((cur.cnh == 4'd1) ? FC_BTPA_SPORT : FC_BTPB_DINFO,
                       {48'd0, a[15:0]});
            nxt.sec = SEC_DONE;
          end
        end
        default: nxt.sec = SEC_DONE;
      endcase
      // every emitting byte closes its field
      if (pend.n != 2'd0) nxt.acc = '0;
    end

    // Closing results on the final byte
    withhold   = (cur.bpos != 2'd3) || (nxt.sec != SEC_DONE);
    fin_status = withhold ? ST_TRUNC : nxt.status;
    hl_res     = '{last: 1'b0, value: {58'd0, nxt.hbc}, code: FC_HDR_LEN};
    st_res     = '{last: 1'b1, value: {61'd0, fin_status}, code: FC_STATUS};

    if (last_byte) begin
      res = '0;
      if (!withhold && pend.n != 2'd0) begin
        res.n = 2'd3;
        res.r[0] = pend.r[0];
        res.r[1] = hl_res;
        res.r[2] = st_res;
      end else begin
        res.n = 2'd2;
        res.r[0] = hl_res;
        res.r[1] = st_res;
      end
      nxt = STATE_RESET;
    end else begin
      res = pend;
      if (cur.bpos != 2'd3) nxt.bpos = cur.bpos + 2'd1;
    end
  end

endmodule
